>>> sv/bge_pkg.sv
// ----------------------------------------------------------------------------
// bge_pkg: shared constants for the background gain envelope
// Widths, register indexes, reset values, phase codes, ambient phase ranges and xorshift.
// ----------------------------------------------------------------------------
package bge_pkg;

    localparam int unsigned CfgIdxW = 3;
    localparam int unsigned CfgDataW = 32;

    localparam logic [CfgIdxW-1:0] REG_AUDIBLE   = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_INAUDIBLE = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_DEPTH     = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_ATTACK    = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_HOLD      = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_RELEASE   = 3'd5;
    localparam logic [CfgIdxW-1:0] REG_SEED      = 3'd6;

    localparam logic signed [15:0] RST_AUDIBLE   = -16'sd1536;
    localparam logic signed [15:0] RST_INAUDIBLE = -16'sd17920;
    localparam logic signed [15:0] RST_DEPTH     = -16'sd3072;
    localparam logic [15:0] RST_ATTACK  = 16'd150;
    localparam logic [15:0] RST_HOLD    = 16'd2000;
    localparam logic [15:0] RST_RELEASE = 16'd3000;
    localparam logic [31:0] RST_SEED    = 32'd1;
    localparam logic [17:0] RST_AMB_LEN = 18'd6000;

    localparam logic [1:0] AMB_FADE_IN  = 2'd0;
    localparam logic [1:0] AMB_AUDIBLE  = 2'd1;
    localparam logic [1:0] AMB_FADE_OUT = 2'd2;
    localparam logic [1:0] AMB_ABSENT   = 2'd3;

    localparam logic [1:0] DUCK_IDLE    = 2'd0;
    localparam logic [1:0] DUCK_ATTACK  = 2'd1;
    localparam logic [1:0] DUCK_HOLD    = 2'd2;
    localparam logic [1:0] DUCK_RELEASE = 2'd3;

    function automatic logic [17:0] amb_min(input logic [1:0] p);
        unique case (p)
            AMB_FADE_IN:  amb_min = 18'd6000;
            AMB_AUDIBLE:  amb_min = 18'd60000;
            AMB_FADE_OUT: amb_min = 18'd8000;
            default:      amb_min = 18'd15000;
        endcase
    endfunction

    function automatic logic [16:0] amb_span(input logic [1:0] p);
        unique case (p)
            AMB_FADE_IN:  amb_span = 17'd6001;
            AMB_AUDIBLE:  amb_span = 17'd120001;
            AMB_FADE_OUT: amb_span = 17'd8001;
            default:      amb_span = 17'd30001;
        endcase
    endfunction

    function automatic logic [31:0] xorshift(input logic [31:0] x);
        logic [31:0] a;
        logic [31:0] b;
        a = x ^ (x << 13);
        b = a ^ (a >> 17);
        xorshift = b ^ (b << 5);
    endfunction

endpackage

>>> sv/background_gain_envelope_core.sv
// ----------------------------------------------------------------------------
// background_gain_envelope_core: ambient cycle plus trigger duck, Q8.8 dB
// Sequencer around one shared divider and one shared multiplier.
// ----------------------------------------------------------------------------
// channel | direction | handshake            | payload
// in      | input     | i_valid / o_ready    | i_operation, i_delta_ms
// out     | output    | o_valid / i_ready    | o_gain_db, o_ambient_phase, o_duck_phase
// cfg     | input     | i_cfg_we             | i_cfg_idx, i_cfg_data
//
// A level in a fixed phase is set directly; an eased level runs a fraction
// division on the shared divider plus three multiply steps.
// A tick beat does bookkeeping, a range draw on the shared divider per ambient
// phase boundary crossed, one step per duck boundary, then the ambient and duck
// levels. A trigger skips the advance and evaluates three levels (old duck,
// ambient, new duck).
// Synchronous active-low reset restores the config, phase and handshake registers.
// The result beat holds in an output register; the next input is taken only
// once the result has been accepted.
// ----------------------------------------------------------------------------
module background_gain_envelope_core
    import bge_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_operation,
    input  logic [15:0]          i_delta_ms,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic signed [16:0]   o_gain_db,
    output logic [1:0]           o_ambient_phase,
    output logic [1:0]           o_duck_phase,
    input  logic                 i_cfg_we,
    input  logic [CfgIdxW-1:0]   i_cfg_idx,
    input  logic [CfgDataW-1:0]  i_cfg_data
);
    typedef enum logic [3:0] {
        S_IDLE, S_AMB, S_DRAW, S_DUCK, S_TRIG,
        S_DIV, S_EASE1, S_EASE2, S_EASE3, S_DONE, S_OUT
    } t_state;

    t_state r_st;
    logic signed [15:0] r_aud, r_inaud, r_depth;
    logic [15:0] r_att, r_hold, r_rel;
    logic [31:0] r_rand;
    logic [1:0]  r_astep, r_dstep;
    logic [17:0] r_ael, r_alen;
    logic [15:0] r_del, r_dlen;
    logic signed [15:0] r_dstart;
    logic [16:0] r_rem;          // time left in this tick
    logic [15:0] r_delta;        // full tick, replayed for the duck
    logic        r_trig;
    logic        r_which;        // 0 ambient level, 1 duck level
    logic        r_draw_wait;
    logic        r_div_wait;
    logic signed [16:0] r_from, r_to;
    logic [16:0] r_t;
    logic [33:0] r_mul;          // shared multiplier result
    logic signed [16:0] r_amb_lvl;
    logic signed [16:0] r_gain;
    logic        r_oval;

    logic        w_div_start;
    logic [33:0] w_div_num;
    logic [17:0] w_div_den;
    logic        w_div_busy;
    logic [33:0] w_quot;
    logic [17:0] w_drem;

    bge_divu u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_busy  (w_div_busy),
        .o_quot  (w_quot),
        .o_rem   (w_drem)
    );

    // ambient left and duck left for the current phase
    logic [17:0] w_aleft;
    logic [16:0] w_dleft;
    assign w_aleft = r_alen - r_ael;
    assign w_dleft = {1'b0, r_dlen - r_del};

    // fraction operands for the level being computed
    logic [17:0] w_fel, w_flen;
    assign w_fel  = r_which ? {2'b0, r_del} : r_ael;
    assign w_flen = r_which ? {2'b0, r_dlen} : r_alen;

    // shared multiplier: 17 x 19 bits in use, one product per step
    logic [33:0] w_ma;
    logic signed [18:0] w_mb;
    logic signed [53:0] w_prod;
    logic [16:0] w_u, w_s;
    logic signed [17:0] w_diff;
    assign w_u    = r_mul[32:16];
    assign w_s    = r_mul[32:16];
    assign w_diff = 18'(r_to) - 18'(r_from);
    always_comb begin
        unique case (r_st)
            S_EASE1: begin w_ma = {17'b0, r_t}; w_mb = $signed({2'b0, r_t}); end
            S_EASE2: begin
                w_ma = {17'b0, w_u};
                w_mb = 19'sd196608 - $signed({1'b0, r_t, 1'b0});
            end
            default: begin w_ma = {17'b0, w_s}; w_mb = $signed({w_diff[17], w_diff}); end
        endcase
    end
    assign w_prod = $signed({1'b0, w_ma}) * w_mb;

    // level from the endpoints and the eased fraction; floor shift
    logic signed [16:0] w_ease;
    assign w_ease = 17'(r_from + 17'(w_prod >>> 16));

    // fixed-phase level, ambient or duck; the duck level before a trigger becomes the trigger start
    logic signed [16:0] w_lvl_fixed;
    always_comb begin
        if (!r_which) w_lvl_fixed = (r_astep == AMB_AUDIBLE) ? 17'(r_aud) : 17'(r_inaud);
        else          w_lvl_fixed = (r_dstep == DUCK_HOLD) ? 17'(r_depth) : 17'sd0;
    end
    logic w_eased;
    assign w_eased = r_which ? (r_dstep == DUCK_ATTACK || r_dstep == DUCK_RELEASE)
                             : (r_astep == AMB_FADE_IN || r_astep == AMB_FADE_OUT);

    logic [31:0] w_next_rand;
    assign w_next_rand = xorshift(r_rand);

    always_comb begin
        w_div_start = 1'b0;
        w_div_num   = '0;
        w_div_den   = '0;
        if (r_st == S_AMB && r_rem != 0 && r_alen != 0 && {1'b0, r_rem} >= w_aleft) begin
            w_div_start = 1'b1;
            w_div_num   = {2'b0, w_next_rand};
            w_div_den   = {1'b0, amb_span(r_astep + 2'd1)};
        end else if (r_st == S_DIV && w_eased && !r_div_wait && w_flen != 0) begin
            w_div_start = 1'b1;
            w_div_num   = {w_fel, 16'b0};
            w_div_den   = w_flen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= S_IDLE;
            r_aud    <= RST_AUDIBLE;
            r_inaud  <= RST_INAUDIBLE;
            r_depth  <= RST_DEPTH;
            r_att    <= RST_ATTACK;
            r_hold   <= RST_HOLD;
            r_rel    <= RST_RELEASE;
            r_rand   <= RST_SEED;
            r_astep  <= AMB_FADE_IN;
            r_ael    <= '0;
            r_alen   <= RST_AMB_LEN;
            r_dstep  <= DUCK_IDLE;
            r_del    <= '0;
            r_dlen   <= '0;
            r_dstart <= '0;
            r_oval   <= 1'b0;
            r_div_wait <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_AUDIBLE:   r_aud   <= i_cfg_data[15:0];
                    REG_INAUDIBLE: r_inaud <= i_cfg_data[15:0];
                    REG_DEPTH:     r_depth <= i_cfg_data[15:0];
                    REG_ATTACK:    r_att   <= i_cfg_data[15:0];
                    REG_HOLD:      r_hold  <= i_cfg_data[15:0];
                    REG_RELEASE:   r_rel   <= i_cfg_data[15:0];
                    REG_SEED:      r_rand  <= (i_cfg_data == '0) ? 32'd1 : i_cfg_data;
                    default: ;
                endcase
            end
            unique case (r_st)
                S_IDLE: begin
                    if (i_valid) begin
                        r_rem  <= {1'b0, i_delta_ms};
                        r_delta <= i_delta_ms;
                        r_trig <= i_operation;
                        r_which <= 1'b1;
                        r_st   <= i_operation ? S_DIV : S_AMB;
                        r_div_wait <= 1'b0;
                    end
                end
                S_AMB: begin
                    // walk ambient phases, one boundary per draw; the duck gets
                    // the whole tick again
                    if (r_rem == 0 || r_alen == 0) begin
                        r_rem <= {1'b0, r_delta};
                        r_st  <= S_DUCK;
                    end else if ({1'b0, r_rem} < w_aleft) begin
                        r_ael <= r_ael + 18'(r_rem);
                        r_rem <= {1'b0, r_delta};
                        r_st  <= S_DUCK;
                    end else begin
                        r_rem   <= 17'(r_rem - 17'(w_aleft));
                        r_astep <= r_astep + 2'd1;
                        r_ael   <= '0;
                        r_rand  <= w_next_rand;
                        r_st    <= S_DRAW;
                        r_draw_wait <= 1'b1;
                    end
                end
                S_DRAW: begin
                    r_draw_wait <= 1'b0;
                    if (!r_draw_wait && !w_div_busy) begin
                        r_alen <= amb_min(r_astep) + w_drem;
                        r_st   <= S_AMB;
                    end
                end
                S_DUCK: begin
                    // one duck phase boundary per cycle
                    if (r_dstep == DUCK_IDLE || r_rem == 0) begin
                        r_which <= 1'b0;
                        r_st    <= S_DIV;
                    end else if (r_rem < w_dleft) begin
                        r_del <= r_del + r_rem[15:0];
                        r_rem <= '0;
                    end else begin
                        r_rem <= r_rem - w_dleft;
                        r_del <= '0;
                        unique case (r_dstep)
                            DUCK_ATTACK: begin r_dstep <= DUCK_HOLD; r_dlen <= r_hold; end
                            DUCK_HOLD:   begin r_dstep <= DUCK_RELEASE; r_dlen <= r_rel; end
                            default:     begin r_dstep <= DUCK_IDLE; r_dlen <= '0; end
                        endcase
                    end
                end
                S_DIV: begin
                    if (!w_eased) begin
                        r_from <= w_lvl_fixed;
                        r_st   <= S_DONE;
                    end else if (!r_div_wait) begin
                        r_div_wait <= 1'b1;
                        if (r_which) begin
                            r_from <= (r_dstep == DUCK_ATTACK) ? 17'(r_dstart) : 17'(r_depth);
                            r_to   <= (r_dstep == DUCK_ATTACK) ? 17'(r_depth) : 17'sd0;
                        end else begin
                            r_from <= (r_astep == AMB_FADE_IN) ? 17'(r_inaud) : 17'(r_aud);
                            r_to   <= (r_astep == AMB_FADE_IN) ? 17'(r_aud) : 17'(r_inaud);
                        end
                        if (w_flen == 0) begin
                            r_t  <= '0;
                            r_st <= S_EASE1;
                        end
                    end else if (!w_div_busy) begin
                        r_t  <= (w_quot > 34'd65536) ? 17'd65536 : w_quot[16:0];
                        r_st <= S_EASE1;
                    end
                end
                S_EASE1: begin r_mul <= w_prod[33:0]; r_st <= S_EASE2; end
                S_EASE2: begin r_mul <= w_prod[33:0]; r_st <= S_EASE3; end
                S_EASE3: begin r_from <= w_ease; r_st <= S_DONE; end
                S_DONE: begin
                    r_div_wait <= 1'b0;
                    if (r_trig) begin
                        // latch current duck level, restart attack, then ambient
                        r_dstart <= r_from[15:0];
                        r_dstep  <= DUCK_ATTACK;
                        r_dlen   <= r_att;
                        r_del    <= '0;
                        r_trig   <= 1'b0;
                        r_which  <= 1'b0;
                        r_st     <= S_DIV;
                    end else if (!r_which) begin
                        r_amb_lvl <= r_from;
                        r_which   <= 1'b1;
                        r_st      <= S_DIV;
                    end else begin
                        r_gain <= 17'(r_amb_lvl + r_from);
                        r_oval <= 1'b1;
                        r_st   <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (i_ready) begin
                        r_oval <= 1'b0;
                        r_st   <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    assign o_ready         = (r_st == S_IDLE);
    assign o_valid         = r_oval;
    assign o_gain_db       = r_gain;
    assign o_ambient_phase = r_astep;
    assign o_duck_phase    = r_dstep;
endmodule

>>> sv/bge_divu.sv
// ----------------------------------------------------------------------------
// bge_divu: shared restoring divider
// One quotient bit per cycle; 34-bit dividend, 18-bit divisor.
// ----------------------------------------------------------------------------
module bge_divu
    import bge_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [33:0] i_num,
    input  logic [17:0] i_den,
    output logic        o_busy,
    output logic [33:0] o_quot,
    output logic [17:0] o_rem
);
    logic [33:0] r_q;
    logic [18:0] r_r;
    logic [17:0] r_d;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic [18:0] w_sh;
    logic [18:0] w_sub;

    assign w_sh  = {r_r[17:0], r_q[33]};
    assign w_sub = w_sh - {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= 6'd34;
            r_q    <= i_num;
            r_r    <= '0;
            r_d    <= i_den;
        end else if (r_busy) begin
            // shift in one dividend bit, subtract when it fits
            if (!w_sub[18]) begin
                r_r <= w_sub;
                r_q <= {r_q[32:0], 1'b1};
            end else begin
                r_r <= w_sh;
                r_q <= {r_q[32:0], 1'b0};
            end
            r_cnt <= r_cnt - 6'd1;
            if (r_cnt == 6'd1) r_busy <= 1'b0;
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_q;
    assign o_rem  = r_r[17:0];
endmodule

>>> sv/bge_checker.sv
// ----------------------------------------------------------------------------
// bge_checker: port-level checks on the envelope core
// Handshake exclusion, ready drop after accept and result stability.
// ----------------------------------------------------------------------------
module bge_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [16:0] o_gain_db
);
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid)) else $error("ready while result pending");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_gain_db))
        else $error("result dropped");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready) else $error("ready after accept");
endmodule

bind background_gain_envelope_core bge_checker u_bge_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_valid   (i_valid),
    .o_ready   (o_ready),
    .o_valid   (o_valid),
    .i_ready   (i_ready),
    .o_gain_db (o_gain_db)
);
